>>> sv/mbw_pkg.sv
// ----------------------------------------------------------------------------
// mbw_pkg - shared types and constants of the write-register frame builder
// Action and status codes, the queued job word and the CRC-16 byte update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbw_pkg;

  // reply collection limit (default of the top-level parameter)
  localparam int MBW_REPLY_MAX_BYTES = 10;

  // configuration register reset values
  localparam logic [7:0]  MBW_ADDR_RESET   = 8'hFF;
  localparam logic [7:0]  MBW_FUNC_RESET   = 8'h06;
  localparam logic [15:0] MBW_TARGET_RESET = 16'h00C2;

  // crc-16/modbus
  localparam logic [15:0] MBW_CRC_INIT = 16'hFFFF;
  localparam logic [15:0] MBW_CRC_POLY = 16'hA001;

  // lamp command range that sets a new value
  localparam logic [7:0] MBW_CMD_LOW  = 8'd3;
  localparam logic [7:0] MBW_CMD_HIGH = 8'd6;

  // index of the last byte of a request frame
  localparam logic [2:0] MBW_LAST_BYTE = 3'd7;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SLAVE_ADDRESS   = 2'd0,
    CFG_FUNCTION_CODE   = 2'd1,
    CFG_TARGET_REGISTER = 2'd2
  } cfg_index_t;

  // input actions
  typedef enum logic [1:0] {
    ACT_SEND    = 2'd0,
    ACT_REPLY   = 2'd1,
    ACT_TIMEOUT = 2'd2
  } action_t;

  // result kinds
  typedef enum logic {
    KIND_FRAME   = 1'b0,
    KIND_OUTCOME = 1'b1
  } kind_t;

  // reply check outcomes
  typedef enum logic [1:0] {
    ST_MISMATCH = 2'd0,
    ST_MATCH    = 2'd1,
    ST_NO_REPLY = 2'd2
  } status_t;

  // job handed from the front end to the frame sender
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  slave_addr;
    logic [7:0]  func;
    logic [15:0] target;
    logic [7:0]  value_lo;
    status_t     status;
  } job_t;

  // one byte through the reflected crc-16
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ MBW_CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

>>> sv/mbw_front.sv
// ----------------------------------------------------------------------------
// mbw_front - command and reply front end
// Holds the configuration registers, the lamp value and the reply collection,
// and turns each accepted word into a job for the frame sender.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbw_front #(
  parameter int REPLY_MAX_BYTES = mbw_pkg::MBW_REPLY_MAX_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  // input word
  input  logic              accept,
  input  logic [1:0]        action,
  input  logic [7:0]        command_code,
  input  logic [7:0]        reply_byte,
  input  logic              reply_end,
  // job out
  output logic              push,
  output mbw_pkg::job_t     job
);
  import mbw_pkg::*;

  logic [7:0]  slave_address;
  logic [7:0]  function_code;
  logic [15:0] target_register;
  logic [2:0]  held_value;
  logic [2:0]  held_value_next;
  logic [7:0]  sent_reg_low;
  logic [7:0]  sent_reg_low_next;
  logic [3:0]  reply_count;
  logic [3:0]  reply_count_next;
  logic [7:0]  reply_third;
  logic [7:0]  reply_third_next;
  logic [7:0]  reply_fourth;
  logic [7:0]  reply_fourth_next;
  logic [7:0]  third_now;
  logic [7:0]  fourth_now;
  logic        in_window;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address   <= MBW_ADDR_RESET;
      function_code   <= MBW_FUNC_RESET;
      target_register <= MBW_TARGET_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SLAVE_ADDRESS:   slave_address   <= cfg_data[7:0];
        CFG_FUNCTION_CODE:   function_code   <= cfg_data[7:0];
        CFG_TARGET_REGISTER: target_register <= cfg_data;
        default: ;
      endcase
    end
  end

  // reply byte capture for the current word
  always_comb begin
    in_window  = {1'b0, reply_count} < 5'(REPLY_MAX_BYTES);
    third_now  = (in_window && reply_count == 4'd3) ? reply_byte : reply_third;
    fourth_now = (in_window && reply_count == 4'd4) ? reply_byte : reply_fourth;
  end

  // classify the word, build the job and the next state
  always_comb begin
    held_value_next   = held_value;
    sent_reg_low_next = sent_reg_low;
    reply_count_next  = reply_count;
    reply_third_next  = reply_third;
    reply_fourth_next = reply_fourth;
    push              = 1'b0;
    job.kind          = KIND_OUTCOME;
    job.slave_addr    = slave_address;
    job.func          = function_code;
    job.target        = target_register;
    job.value_lo      = 8'h00;
    job.status        = ST_NO_REPLY;
    if (accept) begin
      unique case (action_t'(action))
        ACT_SEND: begin
          if (command_code >= MBW_CMD_LOW && command_code <= MBW_CMD_HIGH) begin
            held_value_next = command_code[2:0];
          end
          sent_reg_low_next = target_register[7:0];
          reply_count_next  = '0;
          reply_third_next  = '0;
          reply_fourth_next = '0;
          push              = 1'b1;
          job.kind          = KIND_FRAME;
          job.value_lo      = {5'd0, held_value_next};
        end
        ACT_REPLY: begin
          if (reply_end) begin
            // value high byte is always zero for the lamp codes
            push       = 1'b1;
            job.status = (third_now == sent_reg_low && fourth_now == 8'h00) ?
                         ST_MATCH : ST_MISMATCH;
            reply_count_next  = '0;
            reply_third_next  = '0;
            reply_fourth_next = '0;
          end else begin
            reply_third_next  = third_now;
            reply_fourth_next = fourth_now;
            if (in_window && reply_count != 4'hF) begin
              reply_count_next = reply_count + 4'd1;
            end
          end
        end
        ACT_TIMEOUT: begin
          push              = 1'b1;
          job.status        = ST_NO_REPLY;
          reply_count_next  = '0;
          reply_third_next  = '0;
          reply_fourth_next = '0;
        end
        default: ;
      endcase
    end
  end

  // lamp value and reply collection state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_value   <= '0;
      sent_reg_low <= MBW_TARGET_RESET[7:0];
      reply_count  <= '0;
      reply_third  <= '0;
      reply_fourth <= '0;
    end else begin
      held_value   <= held_value_next;
      sent_reg_low <= sent_reg_low_next;
      reply_count  <= reply_count_next;
      reply_third  <= reply_third_next;
      reply_fourth <= reply_fourth_next;
    end
  end

endmodule

>>> sv/mbw_queue.sv
// ----------------------------------------------------------------------------
// mbw_queue - two-entry job queue
// Decouples the front end from the frame sender so each side stalls alone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mbw_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output mbw_pkg::job_t head
);
  import mbw_pkg::*;

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign head  = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> sv/mbw_sender.sv
// ----------------------------------------------------------------------------
// mbw_sender - frame serialiser with running crc
// Emits a queued job as eight frame bytes or one outcome word into an
// output register, updating the crc one byte per cycle unless the output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbw_sender (
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  input  mbw_pkg::job_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          result_kind,
  output logic [7:0]    frame_byte,
  output logic          frame_last,
  output logic [1:0]    reply_status
);
  import mbw_pkg::*;

  logic [2:0]  byte_idx;
  logic [15:0] crc;
  logic [15:0] crc_cur;
  logic [7:0]  byte_sel;
  logic        advance;
  logic        produce;

  assign advance = !out_valid || !out_stall;
  assign produce = advance && !empty;
  assign pop     = produce && (head.kind == KIND_OUTCOME || byte_idx == MBW_LAST_BYTE);
  assign crc_cur = (byte_idx == 3'd0) ? MBW_CRC_INIT : crc;

  // frame byte select
  always_comb begin
    unique case (byte_idx)
      3'd0: byte_sel = head.slave_addr;
      3'd1: byte_sel = head.func;
      3'd2: byte_sel = head.target[15:8];
      3'd3: byte_sel = head.target[7:0];
      3'd4: byte_sel = 8'h00;
      3'd5: byte_sel = head.value_lo;
      3'd6: byte_sel = crc_cur[7:0];
      3'd7: byte_sel = crc_cur[15:8];
    endcase
  end

  // byte position and crc
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_idx <= '0;
    end else if (produce && head.kind == KIND_FRAME) begin
      byte_idx <= byte_idx + 3'd1;
    end
  end

  // crc covers the six header and value bytes only
  always_ff @(posedge clk) begin
    if (produce && head.kind == KIND_FRAME && byte_idx < 3'd6) begin
      crc <= crc_byte(crc_cur, byte_sel);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      result_kind <= head.kind;
      if (head.kind == KIND_FRAME) begin
        frame_byte   <= byte_sel;
        frame_last   <= byte_idx == MBW_LAST_BYTE;
        reply_status <= ST_MISMATCH;
      end else begin
        frame_byte   <= 8'h00;
        frame_last   <= 1'b1;
        reply_status <= head.status;
      end
    end
  end

endmodule

>>> sv/modbus_write_register_frame.sv
// ----------------------------------------------------------------------------
// modbus_write_register_frame - write-single-register request builder
// Builds Modbus RTU lamp requests with crc and checks the echoed reply.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_valid / in_stall) carry an action: send a lamp command,
//   deliver one reply byte, or report a reply timeout. Result words
//   (out_valid / out_stall) are either request bytes (eight per send, the
//   last flagged by frame_last) or one reply check outcome.
//   Configuration writes (cfg_valid / cfg_ready, cfg_index, cfg_data) set the
//   slave address, function code and target register; cfg_ready is always
//   high and writes are expected only while the block is idle.
//   An accepted word passes through the job queue and the output register
//   before its first result is presented. One result word is given per
//   cycle while out_stall is low; a send occupies the output for its eight
//   bytes, set by the byte-per-cycle serialiser and its crc update.
//   Reply bytes without an end mark produce nothing.
//   A two-entry queue sits between the front end and the serialiser; input
//   stalls only when that queue is full.
//   Reset restores the register defaults, clears the lamp value and the reply
//   collection and empties the queue and output register.
//   While out_stall is high the presented result holds and queued jobs wait.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modbus_write_register_frame #(
  parameter int REPLY_MAX_BYTES = mbw_pkg::MBW_REPLY_MAX_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  command_code,
  input  logic [7:0]  reply_byte,
  input  logic        reply_end,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [7:0]  frame_byte,
  output logic        frame_last,
  output logic [1:0]  reply_status
);
  import mbw_pkg::*;

  logic accept;
  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t job;
  job_t head;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !full;

  // front end
  mbw_front #(
    .REPLY_MAX_BYTES(REPLY_MAX_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .action       (action),
    .command_code (command_code),
    .reply_byte   (reply_byte),
    .reply_end    (reply_end),
    .push         (push),
    .job          (job)
  );

  // job queue
  mbw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (job),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  // frame serialiser
  mbw_sender u_sender (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .frame_byte   (frame_byte),
    .frame_last   (frame_last),
    .reply_status (reply_status)
  );

endmodule
